// ----- hw/rtl/cassette_fsk_modulator_defines.svh -----
// Assertion macros for the cassette FSK modulator checker.
// Needs nothing else; included by the checker file.
`ifndef CASSETTE_FSK_MODULATOR_DEFINES_SVH
`define CASSETTE_FSK_MODULATOR_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define FSKM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define FSKM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/fskm_pkg.sv -----
// Shared types and constants for the cassette FSK modulator.
// No dependencies; imported by every other file of the block but fskm_cell and the defines.
package fskm_pkg;

  localparam int unsigned WIN_DEPTH = 8;
  localparam int unsigned WIN_IDX_W = $clog2(WIN_DEPTH);

  // Tape header signature, entry 0 is the first byte on tape.
  localparam logic [WIN_DEPTH-1:0][7:0] SIGNATURE =
    {8'h74, 8'h7D, 8'h13, 8'hCC, 8'hBA, 8'hDE, 8'hA6, 8'h1F};

  // Work handed to the run generator.
  localparam logic [1:0] JOB_BYTE      = 2'd0;
  localparam logic [1:0] JOB_HEADER    = 2'd1;
  localparam logic [1:0] JOB_BAD_SIG   = 2'd2;
  localparam logic [1:0] JOB_EMPTY     = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_SIG = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  localparam logic [1:0] REG_AMPLITUDE       = 2'd0;
  localparam logic [1:0] REG_BIT_PERIOD      = 2'd1;
  localparam logic [1:0] REG_SILENCE_PERIODS = 2'd2;
  localparam logic [1:0] REG_LEADER_PERIODS  = 2'd3;

  localparam logic [14:0] RST_AMPLITUDE       = 15'd32767;
  localparam logic [6:0]  RST_BIT_PERIOD      = 7'd16;
  localparam logic [15:0] RST_SILENCE_PERIODS = 16'd1000;
  localparam logic [15:0] RST_LEADER_PERIODS  = 16'd4000;

  // Bit runs per byte: start, eight data, three stop.
  localparam logic [3:0] BYTE_LAST_STEP = 4'd11;
  localparam logic [3:0] BYTE_LAST_DATA = 4'd8;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] start_amplitude;
    logic [21:0]        half_width;
    logic [17:0]        half_cycles;
    logic               last;
    logic [1:0]         status;
  } out_beat_t;

  typedef struct packed {
    logic [14:0] amplitude;
    logic [6:0]  bit_period;
    logic [15:0] silence_periods;
    logic [15:0] leader_periods;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } job_t;

  typedef struct packed {
    logic                 shift;
    logic                 wr;
    logic [WIN_IDX_W-1:0] wr_idx;
    logic [7:0]           wr_byte;
  } win_ctrl_t;

endpackage

// ----- hw/rtl/cassette_fsk_modulator.sv -----
// Top level of the cassette FSK modulator: header check, window control and config registers.
// Depends on fskm_pkg, fskm_window and fskm_run_gen.
//
//  channel | direction | handshake      | beat
//  --------+-----------+----------------+--------------------------------------------------
//  in_     | in        | valid / stall  | in_beat_t: op, data_byte
//  out_    | out       | valid / stall  | out_beat_t: amplitude, width, count, last, status
//  cfg_    | in        | valid / ready  | cfg_index, cfg_data (ready always high)
//
// A data byte sent from the window gives 12 output beats, a leader header 2 and a status
// beat 1, one beat a cycle while out_stall is low; an accepted beat is registered as a job
// before its beats enter the output register. The next input beat is taken in the cycle the
// final beat is handed over; beats that only fill the window are taken at once while idle.
// Reset is synchronous and clears control state only; the window contents stay undefined.
// in_stall is high while the generator holds beats besides the one it hands over.
module cassette_fsk_modulator import fskm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [1:0] MODE_WAIT = 2'd0;
  localparam logic [1:0] MODE_PEND = 2'd1;
  localparam logic [1:0] MODE_RUN  = 2'd2;
  localparam logic [1:0] MODE_ERR  = 2'd3;

  cfg_t       cfg_r, cfg_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [3:0] fill_r, fill_nxt;

  logic       in_acc;
  logic       gen_free;
  logic       job_load;
  job_t       job;
  win_ctrl_t  wctrl;
  logic [7:0] head;
  logic       sig_match;

  assign cfg_ready = 1'b1;
  assign in_stall  = !gen_free;
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_AMPLITUDE:       cfg_nxt.amplitude       = cfg_data[14:0];
        REG_BIT_PERIOD:      cfg_nxt.bit_period      = cfg_data[6:0];
        REG_SILENCE_PERIODS: cfg_nxt.silence_periods = cfg_data;
        REG_LEADER_PERIODS:  cfg_nxt.leader_periods  = cfg_data;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    mode_nxt      = mode_r;
    fill_nxt      = fill_r;
    job_load      = 1'b0;
    job.kind      = JOB_BAD_SIG;
    job.data      = head;
    wctrl.shift   = 1'b0;
    wctrl.wr      = 1'b0;
    wctrl.wr_idx  = fill_r[WIN_IDX_W-1:0];
    wctrl.wr_byte = in_data.data_byte;

    if (in_acc) begin
      unique case (mode_r)
        MODE_WAIT: begin
          // While waiting, the fill count tracks how much of the signature has matched.
          if (!in_data.op && (in_data.data_byte == SIGNATURE[fill_r[WIN_IDX_W-1:0]])) begin
            if (fill_r[WIN_IDX_W-1:0] == WIN_IDX_W'(WIN_DEPTH - 1)) begin
              mode_nxt = MODE_PEND;
              fill_nxt = 4'd0;
            end else begin
              fill_nxt = fill_r + 4'd1;
            end
          end else begin
            mode_nxt = MODE_ERR;
            job_load = 1'b1;
          end
        end
        MODE_PEND: begin
          job_load = 1'b1;
          if (in_data.op) begin
            job.kind = JOB_EMPTY;
          end else begin
            job.kind     = JOB_HEADER;
            wctrl.wr     = 1'b1;
            wctrl.wr_idx = '0;
            fill_nxt     = 4'd1;
            mode_nxt     = MODE_RUN;
          end
        end
        MODE_RUN: begin
          if (in_data.op) begin
            job_load = 1'b1;
            if (fill_r != 4'd0) begin
              job.kind    = JOB_BYTE;
              wctrl.shift = 1'b1;
              fill_nxt    = fill_r - 4'd1;
            end else begin
              job.kind = JOB_EMPTY;
            end
          end else if (fill_r[WIN_IDX_W]) begin
            // Full window: a repeated header becomes a new leader, anything else sends a byte.
            job_load = 1'b1;
            wctrl.wr = 1'b1;
            if (sig_match) begin
              job.kind     = JOB_HEADER;
              wctrl.wr_idx = '0;
              fill_nxt     = 4'd1;
            end else begin
              job.kind     = JOB_BYTE;
              wctrl.shift  = 1'b1;
              wctrl.wr_idx = WIN_IDX_W'(WIN_DEPTH - 1);
            end
          end else begin
            wctrl.wr = 1'b1;
            fill_nxt = fill_r + 4'd1;
          end
        end
        MODE_ERR: begin
          job_load = 1'b1;
        end
        default: begin
          mode_nxt = MODE_ERR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.amplitude       <= RST_AMPLITUDE;
      cfg_r.bit_period      <= RST_BIT_PERIOD;
      cfg_r.silence_periods <= RST_SILENCE_PERIODS;
      cfg_r.leader_periods  <= RST_LEADER_PERIODS;
      mode_r                <= MODE_WAIT;
      fill_r                <= 4'd0;
    end else begin
      cfg_r  <= cfg_nxt;
      mode_r <= mode_nxt;
      fill_r <= fill_nxt;
    end
  end

  fskm_window u_window (
    .clk       (clk),
    .ctrl      (wctrl),
    .head      (head),
    .sig_match (sig_match)
  );

  fskm_run_gen u_run_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_load  (job_load),
    .job       (job),
    .gen_free  (gen_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/fskm_cell.sv -----
// One byte cell of the look-ahead window with its signature compare.
// Standalone; instantiated in a row by fskm_window.
module fskm_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic       wr_en,
  input  logic [7:0] wr_byte,
  input  logic [7:0] shift_in,
  input  logic [7:0] sig_byte,
  input  logic       match_in,
  output logic [7:0] data_out,
  output logic       match_out
);

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  // A write beats a shift, so the tail cell can shift and take the new byte at once.
  always_comb begin
    data_nxt = data_r;
    if (wr_en) begin
      data_nxt = wr_byte;
    end else if (shift_en) begin
      data_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out  = data_r;
  assign match_out = match_in & (data_r == sig_byte);

endmodule

// ----- hw/rtl/fskm_window.sv -----
// Eight-byte look-ahead window built as a row of fskm_cell instances.
// Depends on fskm_pkg and fskm_cell.
module fskm_window import fskm_pkg::*; (
  input  logic       clk,
  input  win_ctrl_t  ctrl,
  output logic [7:0] head,
  output logic       sig_match
);

  logic [7:0]         cell_data [WIN_DEPTH];
  logic [WIN_DEPTH:0] match_chain;

  assign match_chain[0] = 1'b1;

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    logic [7:0] nbr;
    logic       wr_here;

    if (i == WIN_DEPTH - 1) begin : g_tail
      assign nbr = cell_data[i];
    end else begin : g_body
      assign nbr = cell_data[i+1];
    end

    assign wr_here = ctrl.wr && (ctrl.wr_idx == WIN_IDX_W'(i));

    fskm_cell u_cell (
      .clk       (clk),
      .shift_en  (ctrl.shift),
      .wr_en     (wr_here),
      .wr_byte   (ctrl.wr_byte),
      .shift_in  (nbr),
      .sig_byte  (SIGNATURE[i]),
      .match_in  (match_chain[i]),
      .data_out  (cell_data[i]),
      .match_out (match_chain[i+1])
    );
  end

  assign head      = cell_data[0];
  assign sig_match = match_chain[WIN_DEPTH];

endmodule

// ----- hw/rtl/fskm_run_gen.sv -----
// Run generator: turns one job into its runs, one beat a cycle unless stalled, into an
// output register. Depends on fskm_pkg.
module fskm_run_gen import fskm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      job_load,
  input  job_t      job,
  output logic      gen_free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic       busy_r, busy_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [3:0] step_r, step_nxt;
  logic       pol_r, pol_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_beat_t  out_data_r, out_data_nxt;

  logic              out_load;
  logic              last_step;
  logic              bit_val;
  logic              is_tone;
  logic [15:0]       amp_pos;
  logic [15:0]       amp_sgn;
  logic [21:0]       hw_quarter;
  logic [21:0]       hw_half;
  out_beat_t         beat;

  assign out_load = !out_valid_r || !out_stall;

  always_comb begin
    case (kind_r)
      JOB_BYTE:   last_step = (step_r == BYTE_LAST_STEP);
      JOB_HEADER: last_step = (step_r != 4'd0);
      default:    last_step = 1'b1;
    endcase
  end

  assign gen_free = !busy_r || (out_load && last_step);

  assign amp_pos    = {1'b0, cfg.amplitude};
  assign amp_sgn    = pol_r ? amp_pos : (16'd0 - amp_pos);
  assign hw_quarter = 22'(cfg.bit_period >> 2);
  assign hw_half    = 22'(cfg.bit_period >> 1);

  // Step 0 is the start bit, steps 1 to 8 the data LSB first, the rest stop bits.
  assign bit_val = (step_r == 4'd0) ? 1'b0 :
                   (step_r <= BYTE_LAST_DATA) ? byte_r[0] : 1'b1;

  always_comb begin
    beat      = '0;
    beat.last = last_step;
    is_tone   = 1'b0;
    unique case (kind_r)
      JOB_BYTE: begin
        is_tone              = 1'b1;
        beat.start_amplitude = amp_sgn;
        beat.half_width      = bit_val ? hw_quarter : hw_half;
        beat.half_cycles     = bit_val ? 18'd4 : 18'd2;
        beat.status          = ST_OK;
      end
      JOB_HEADER: begin
        beat.status = ST_OK;
        if (step_r == 4'd0) begin
          beat.half_width  = 22'(cfg.bit_period);
          beat.half_cycles = 18'(cfg.silence_periods);
        end else begin
          is_tone              = 1'b1;
          beat.start_amplitude = amp_sgn;
          beat.half_width      = hw_quarter;
          beat.half_cycles     = {cfg.leader_periods, 2'b00};
        end
      end
      JOB_BAD_SIG: beat.status = ST_BAD_SIG;
      JOB_EMPTY:   beat.status = ST_EMPTY;
      default:     beat.status = ST_EMPTY;
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    step_nxt      = step_r;
    pol_nxt       = pol_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_load) begin
      out_valid_nxt = busy_r;
      if (busy_r) begin
        out_data_nxt = beat;
        // The sign flips once per half-cycle, so only an odd count leaves it changed.
        if (is_tone && beat.half_cycles[0]) begin
          pol_nxt = !pol_r;
        end
        if (step_r != 4'd0) begin
          byte_nxt = byte_r >> 1;
        end
        step_nxt = step_r + 4'd1;
        if (last_step) begin
          busy_nxt = 1'b0;
        end
      end
    end

    if (job_load) begin
      busy_nxt = 1'b1;
      kind_nxt = job.kind;
      byte_nxt = job.data;
      step_nxt = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pol_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pol_r       <= pol_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    byte_r     <= byte_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/fskm_checker.sv -----
// Port-level checker for the cassette FSK modulator, bound to the top level.
// Depends on fskm_pkg and cassette_fsk_modulator_defines.svh.
`include "cassette_fsk_modulator_defines.svh"

module fskm_checker import fskm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  logic err_seen_r;

  // Remembers that a bad-signature beat has been delivered; the error is sticky.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
    end else if (out_valid && !out_stall && (out_data.status == ST_BAD_SIG)) begin
      err_seen_r <= 1'b1;
    end
  end

  `FSKM_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled output beat changed")

  `FSKM_ASSERT(a_status_alone, clk, rst_n, out_valid && (out_data.status != ST_OK) |-> out_data.last && (out_data.half_width == 22'd0) && (out_data.half_cycles == 18'd0) && (out_data.start_amplitude == 16'sd0), "status beat is not a lone empty beat")

  `FSKM_ASSERT(a_error_sticky, clk, rst_n, out_valid && err_seen_r |-> (out_data.status == ST_BAD_SIG), "beat after signature error is not an error beat")

  `FSKM_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "output valid right after reset")

endmodule

bind cassette_fsk_modulator fskm_checker u_fskm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- verif/tb.sv -----
// Self-checking testbench for cassette_fsk_modulator: tape bytes in, square-wave runs out.
// Depends on fskm_pkg and the RTL only; a built-in predictor tracks the expected runs.
module tb;
  import fskm_pkg::*;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 200;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PRINT_CAP     = 40;

  typedef enum logic [1:0] {TAPE_WAIT, TAPE_PEND, TAPE_RUN, TAPE_ERR} tape_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_AMPLITUDE;
  logic [15:0] cfg_data = '0;

  in_beat_t  tape_queue[$];
  out_beat_t expected_runs[$];
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic      out_hold = 1'b0;

  // Predictor state.
  tape_mode_t      tape_mode = TAPE_WAIT;
  logic [7:0][7:0] win_bytes = '0;
  int              win_fill = 0;
  logic            polarity_pos = 1'b1;
  cfg_t            cfg_regs = '{RST_AMPLITUDE, RST_BIT_PERIOD, RST_SILENCE_PERIODS,
                                RST_LEADER_PERIODS};

  cassette_fsk_modulator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic void add_run(logic signed [15:0] amp, logic [21:0] hw,
                                  logic [17:0] hc, logic [1:0] st);
    out_beat_t r;
    r.start_amplitude = amp;
    r.half_width = hw;
    r.half_cycles = hc;
    r.last = 1'b0;
    r.status = st;
    expected_runs.push_back(r);
  endfunction

  // Polarity flips once per half-cycle, so only an odd count changes it.
  function automatic void add_tone(logic [21:0] hw, logic [17:0] hc);
    logic signed [15:0] mag;
    mag = {1'b0, cfg_regs.amplitude};
    add_run(polarity_pos ? mag : -mag, hw, hc, ST_OK);
    if (hc[0]) polarity_pos = ~polarity_pos;
  endfunction

  // Silence carries no polarity and never toggles it.
  function automatic void add_header();
    add_run(16'sd0, 22'(cfg_regs.bit_period), 18'(cfg_regs.silence_periods), ST_OK);
    add_tone(22'(cfg_regs.bit_period >> 2), {cfg_regs.leader_periods, 2'b00});
  endfunction

  function automatic void add_byte(logic [7:0] b);
    logic bit_val;
    for (int i = 0; i < 12; i++) begin
      if (i == 0) bit_val = 1'b0;
      else if (i < 9) bit_val = b[i-1];
      else bit_val = 1'b1;
      if (bit_val) add_tone(22'(cfg_regs.bit_period >> 2), 18'd4);
      else add_tone(22'(cfg_regs.bit_period >> 1), 18'd2);
    end
  endfunction

  function automatic void shift_window();
    win_bytes = {win_bytes[7], win_bytes[7:1]};
    if (win_fill > 0) win_fill--;
  endfunction

  task automatic predict_runs(input in_beat_t beat);
    int        n0;
    out_beat_t tail;
    n0 = expected_runs.size();
    if (tape_mode == TAPE_ERR) begin
      add_run(16'sd0, '0, '0, ST_BAD_SIG);
    end else if (beat.op == OP_DRAIN) begin
      if (tape_mode == TAPE_WAIT) begin
        tape_mode = TAPE_ERR;
        add_run(16'sd0, '0, '0, ST_BAD_SIG);
      end else if (tape_mode == TAPE_RUN && win_fill > 0) begin
        add_byte(win_bytes[0]);
        shift_window();
      end else begin
        add_run(16'sd0, '0, '0, ST_EMPTY);
      end
    end else if (tape_mode == TAPE_WAIT) begin
      if (win_fill > 7 || beat.data_byte != SIGNATURE[win_fill]) begin
        tape_mode = TAPE_ERR;
        add_run(16'sd0, '0, '0, ST_BAD_SIG);
      end else begin
        win_fill++;
        if (win_fill == 8) begin
          tape_mode = TAPE_PEND;
          win_fill = 0;
        end
      end
    end else if (tape_mode == TAPE_PEND) begin
      add_header();
      win_bytes[0] = beat.data_byte;
      win_fill = 1;
      tape_mode = TAPE_RUN;
    end else begin
      // A full window that holds the signature is replaced by a fresh header.
      if (win_fill >= 8) begin
        if (win_bytes == SIGNATURE) begin
          add_header();
          win_fill = 0;
        end else begin
          add_byte(win_bytes[0]);
          shift_window();
        end
      end
      if (win_fill > 7) win_fill = 7;
      win_bytes[win_fill] = beat.data_byte;
      win_fill++;
    end
    if (expected_runs.size() > n0) begin
      tail = expected_runs.pop_back();
      tail.last = 1'b1;
      expected_runs.push_back(tail);
    end
  endtask

  task automatic report_mismatch(input string what, input out_beat_t got,
                                 input out_beat_t want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("run check, %s: got amp %0d hw %0d hc %0d last %0b st %0d,",
               what, got.start_amplitude, got.half_width, got.half_cycles, got.last,
               got.status, " want amp %0d hw %0d hc %0d last %0b st %0d",
               want.start_amplitude, want.half_width, want.half_cycles, want.last,
               want.status);
  endtask

  task automatic check_run(input out_beat_t got);
    out_beat_t want;
    if (expected_runs.size() == 0) begin
      report_mismatch("nothing expected", got, '0);
    end else begin
      want = expected_runs.pop_front();
      if (got.start_amplitude !== want.start_amplitude)
        report_mismatch("start_amplitude", got, want);
      if (got.half_width !== want.half_width) report_mismatch("half_width", got, want);
      if (got.half_cycles !== want.half_cycles) report_mismatch("half_cycles", got, want);
      if (got.last !== want.last) report_mismatch("last", got, want);
      if (got.status !== want.status) report_mismatch("status", got, want);
    end
  endtask

  // Input driver: a beat stays on the bus until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_runs(in_data);
      if (!in_valid || !in_stall) begin
        if (tape_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= tape_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor and receiver stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_run(out_data);
    out_stall <= out_hold || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic queue_beat(input logic op, input logic [7:0] b);
    in_beat_t t;
    t.op = op;
    t.data_byte = b;
    tape_queue.push_back(t);
  endtask

  // Mostly bytes, with embedded signatures and bursts of drains.
  task automatic queue_stream(input int count);
    int k;
    int j;
    int r;
    k = 0;
    while (k < count) begin
      r = $urandom_range(99);
      if (r < 8) begin
        for (j = 0; j < 8; j++) queue_beat(OP_PUSH, SIGNATURE[j]);
        k += 8;
      end else if (r < 20) begin
        j = $urandom_range(9, 1);
        repeat (j) queue_beat(OP_DRAIN, 8'($urandom));
        k += j;
      end else begin
        queue_beat(OP_PUSH, 8'($urandom));
        k++;
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_AMPLITUDE:       cfg_regs.amplitude = value[14:0];
      REG_BIT_PERIOD:      cfg_regs.bit_period = value[6:0];
      REG_SILENCE_PERIODS: cfg_regs.silence_periods = value;
      REG_LEADER_PERIODS:  cfg_regs.leader_periods = value;
      default: ;
    endcase
  endtask

  // Unused upper bits of the narrow registers get random junk.
  task automatic set_config(input int amp, input int bp, input int sil, input int lead);
    write_reg(REG_AMPLITUDE, {1'($urandom), 15'(amp)});
    write_reg(REG_BIT_PERIOD, {9'($urandom), 7'(bp)});
    write_reg(REG_SILENCE_PERIODS, 16'(sil));
    write_reg(REG_LEADER_PERIODS, 16'(lead));
  endtask

  // Window-only beats give no run, so allow the block some cycles to settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (tape_queue.size() != 0 || in_valid || expected_runs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int stall_pct, input int count,
                           input bit squeeze);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    queue_stream(count);
    if (squeeze) begin
      @(posedge clk);
      out_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_hold <= 1'b0;
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Header, drain right after the signature, drain of a lone byte, drain of an empty
    // window, then a signature inside the stream followed by extreme bytes.
    for (int j = 0; j < 8; j++) queue_beat(OP_PUSH, SIGNATURE[j]);
    queue_beat(OP_DRAIN, 8'hFF);
    queue_beat(OP_PUSH, 8'h00);
    queue_beat(OP_DRAIN, 8'h00);
    queue_beat(OP_DRAIN, 8'hA5);
    for (int j = 0; j < 8; j++) queue_beat(OP_PUSH, SIGNATURE[j]);
    queue_beat(OP_PUSH, 8'hFF);
    queue_beat(OP_PUSH, 8'h55);
    queue_beat(OP_PUSH, 8'hAA);
    queue_beat(OP_PUSH, 8'h01);
    queue_beat(OP_PUSH, 8'h80);
    wait_drained();

    set_config(32767, 64, 65535, 65535);
    run_phase(0, 0, 46, 1'b0);

    set_config(1, 4, 0, 1);
    run_phase(47, 0, 46, 1'b0);

    // Odd and tiny bit periods truncate the half widths; an empty leader is allowed.
    set_config($urandom_range(32767, 1), 2 * $urandom_range(3, 0) + 1,
               $urandom_range(65535), 0);
    run_phase(0, 47, 46, 1'b0);

    set_config($urandom_range(32767, 1), 4 * $urandom_range(16, 1),
               $urandom_range(65535), $urandom_range(65535, 1));
    run_phase(34, 34, 50, 1'b1);

    set_config($urandom_range(32767, 1), 127, 2 * $urandom_range(100, 0) + 1,
               $urandom_range(65535, 1));
    run_phase(34, 34, 46, 1'b0);

    set_config($urandom_range(32767, 1), 4 * $urandom_range(16, 1),
               $urandom_range(65535), $urandom_range(65535, 1));
    run_phase(47, 47, 46, 1'b0);

    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
